// ----- src/srma_pkg.sv -----
// ---------------------------------------------------------------------------
// srma_pkg: shared definitions for the spike rejecting moving average
// Data widths, register map, reset values and divider status type.
// ---------------------------------------------------------------------------
`default_nettype none

package srma_pkg;

  localparam int unsigned DATA_W      = 16;  // sample, average, threshold
  localparam int unsigned MOD_W       = 17;  // modulus, sample limit + 1
  localparam int unsigned WINDOW_DEF  = 8;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;

  // register indexes (byte address = 4 * index)
  localparam logic REG_SPIKE_THRESHOLD = 1'b0;
  localparam logic REG_SAMPLE_LIMIT    = 1'b1;

  localparam logic [DATA_W-1:0] THRESHOLD_RST = 16'd256;
  localparam logic [DATA_W-1:0] MAX_VALUE_RST = 16'd4095;

  typedef struct packed {
    logic busy;
    logic done;
  } srma_div_sts_t;

endpackage

`default_nettype wire

// ----- src/spike_rejecting_moving_average_unit.sv -----
// Steps for an accepted sample: modulo reduction in the divider, spike check, sum
// update, average division, result. A rejected sample goes from the check to the result.
// One sample at a time: the next input beat can be taken in the cycle the result shows,
// so no new sample enters before the last is through; an output stall holds the unit.
// Reset: running sum, fill count and average cleared; threshold 256, max 4095.
// ---------------------------------------------------------------------------
// spike_rejecting_moving_average_unit: moving average with spike rejection
// Samples reduced modulo max+1, compared against the average, accepted ones kept in a ring.
// ---------------------------------------------------------------------------
`default_nettype none

module spike_rejecting_moving_average_unit #(
  parameter int unsigned WINDOW = srma_pkg::WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [srma_pkg::DATA_W-1:0]   raw_sample_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [srma_pkg::DATA_W-1:0]   average_o,
  output logic                               rejected_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srma_pkg::APB_AW-1:0]   paddr,
  input  wire logic [srma_pkg::APB_DW-1:0]   pwdata,
  output logic      [srma_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);
  import srma_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_AVGS = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [DATA_W-1:0] thr_q, max_q;
  logic [IDX_W-1:0]  slot_q, slot_d, slot_nxt;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DATA_W-1:0] avg_q, avg_d;
  logic [DATA_W-1:0] s_q, s_d;
  logic              rej_q, rej_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_avg_q, out_avg_d;
  logic              out_rej_q, out_rej_d;

  logic              in_beat;
  logic              cfg_wr;
  logic              full;
  logic              reject;
  logic [DATA_W:0]   hi_lim;
  logic [DATA_W-1:0] old_smp;

  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic              div_start;
  logic [SUM_W-1:0]  div_dvd;
  logic [MOD_W-1:0]  div_dvs;
  logic [STEP_W-1:0] div_steps;
  srma_div_sts_t     div_sts;
  logic [SUM_W-1:0]  div_quo;
  logic [MOD_W-1:0]  div_rem;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_SPIKE_THRESHOLD: prdata = {{(APB_DW-DATA_W){1'b0}}, thr_q};
      REG_SAMPLE_LIMIT:    prdata = {{(APB_DW-DATA_W){1'b0}}, max_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      max_q <= MAX_VALUE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SPIKE_THRESHOLD: thr_q <= pwdata[DATA_W-1:0];
        REG_SAMPLE_LIMIT:    max_q <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- datapath
  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign slot_nxt   = (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + IDX_W'(1);
  assign full       = (fill_q == CNT_W'(WINDOW));
  // slots past the fill count were never written, so zero is used in place of the read
  assign old_smp    = full ? ram_rdata : '0;
  assign hi_lim     = {1'b0, avg_q} + {1'b0, thr_q};

  always_comb begin
    reject = 1'b0;
    if (full) begin
      if ((avg_q >= thr_q) && (s_q < avg_q - thr_q)) begin
        reject = 1'b1;
      end else if ({1'b0, s_q} > hi_lim) begin
        reject = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    s_d         = s_q;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_avg_d   = out_avg_q;
    out_rej_d   = out_rej_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    div_dvd     = {raw_sample_i, {(SUM_W-DATA_W){1'b0}}};
    div_dvs     = {1'b0, max_q} + MOD_W'(1);
    div_steps   = STEP_W'(DATA_W);

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          div_start = 1'b1;
          ram_re    = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (div_sts.done) begin
          s_d     = div_rem[DATA_W-1:0];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (reject) begin
          rej_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          rej_d   = 1'b0;
          ram_we  = 1'b1;
          slot_d  = slot_nxt;
          fill_d  = full ? fill_q : fill_q + CNT_W'(1);
          sum_d   = sum_q - SUM_W'(old_smp);
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        sum_d   = sum_q + SUM_W'(s_q);
        state_d = S_AVGS;
      end
      S_AVGS: begin
        div_start = 1'b1;
        div_dvd   = sum_q;
        div_dvs   = MOD_W'(fill_q);
        div_steps = STEP_W'(SUM_W);
        state_d   = S_AVG;
      end
      S_AVG: begin
        if (div_sts.done) begin
          avg_d   = div_quo[DATA_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_avg_d   = avg_q;
          out_rej_d   = rej_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= IDX_W'(WINDOW - 1);
      fill_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    rej_q     <= rej_d;
    out_avg_q <= out_avg_d;
    out_rej_q <= out_rej_d;
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign rejected_o  = out_rej_q;

  // ---- sample ring
  srma_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_nxt),
    .wdata_i (s_q),
    .re_i    (ram_re),
    .raddr_i (slot_nxt),
    .rdata_o (ram_rdata)
  );

  // ---- shared serial divider: modulo first, then average
  srma_div #(
    .DVD_W  (SUM_W),
    .DVS_W  (MOD_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .steps_i     (div_steps),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_div_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_MOD || state_q == S_AVG))
    else $error("divider finished outside a wait state");

  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result beat raised outside completion state");

  a_reject_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && !full) |=> state_q == S_ADD)
    else $error("sample rejected before window filled");
`endif

endmodule

`default_nettype wire

// ----- src/srma_ram.sv -----
// ---------------------------------------------------------------------------
// srma_ram: generic single write port RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/srma_div.sv -----
// ---------------------------------------------------------------------------
// srma_div: bit-serial restoring divider
// Dividend is loaded left aligned and shifted out one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srma_div #(
  parameter int unsigned DVD_W  = 19,
  parameter int unsigned DVS_W  = 17,
  parameter int unsigned STEP_W = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DVD_W-1:0]     dividend_i,
  input  wire logic [DVS_W-1:0]     divisor_i,
  input  wire logic [STEP_W-1:0]    steps_i,
  output srma_pkg::srma_div_sts_t   sts_o,
  output logic      [DVD_W-1:0]     quotient_o,
  output logic      [DVS_W-1:0]     remainder_o
);
  import srma_pkg::*;

  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // remainder stays below the divisor, so one extra bit holds the trial
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ----- tb/spike_rejecting_moving_average_unit_test.sv -----
// ---------------------------------------------------------------------------
// spike_rejecting_moving_average_unit_test: self-checking bench for the unit
// Drives samples under random idle and stall patterns, predicts the average
// and spike flag per beat, and checks each result in order.
// ---------------------------------------------------------------------------
`default_nettype none

module spike_rejecting_moving_average_unit_test;
  import srma_pkg::*;

  localparam int unsigned WINDOW        = WINDOW_DEF;
  localparam int          NUM_ROUNDS    = 16;
  localparam int          ROUND_ITEMS   = 118;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          WATCHDOG_MAX  = 5000;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic              rejected;
  } srma_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [DATA_W-1:0]   raw_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [DATA_W-1:0]   average_o;
  logic                rejected_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  spike_rejecting_moving_average_unit #(
    .WINDOW (WINDOW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o),
    .rejected_o   (rejected_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the filter state and registers
  logic [DATA_W-1:0] ring_q [WINDOW] = '{default: '0};
  int unsigned       slot_q  = WINDOW - 1;
  int unsigned       fill_q  = 0;
  logic [18:0]       sum_q   = '0;
  logic [DATA_W-1:0] avg_q   = '0;
  logic [DATA_W-1:0] thr_q   = THRESHOLD_RST;
  logic [DATA_W-1:0] max_q   = MAX_VALUE_RST;

  logic [DATA_W-1:0] pending_samples [$];
  srma_result_t      expected_averages [$];

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic sender_hold   = 1'b0;
  int   hold_requests = 0;
  int   hold_served   = 0;
  int   hold_left     = 0;
  int   error_count   = 0;
  int   quiet_cycles  = 0;

  function automatic srma_result_t filter_sample(input logic [DATA_W-1:0] raw);
    logic [MOD_W-1:0]  modulus;
    logic [DATA_W-1:0] s;
    logic [MOD_W-1:0]  upper;
    logic              reject;
    modulus = {1'b0, max_q} + 1'b1;
    s       = DATA_W'({1'b0, raw} % modulus);
    upper   = {1'b0, avg_q} + {1'b0, thr_q};  // no wrap at the top
    reject  = 1'b0;
    if (fill_q >= WINDOW) begin
      if (avg_q >= thr_q && s < avg_q - thr_q) reject = 1'b1;
      else if ({1'b0, s} > upper) reject = 1'b1;
    end
    if (!reject) begin
      if (fill_q < WINDOW) fill_q++;
      slot_q = (slot_q + 1) % WINDOW;
      // unwritten slots hold zero, so the fill phase subtracts nothing
      sum_q  = sum_q - 19'(ring_q[slot_q]) + 19'(s);
      ring_q[slot_q] = s;
      avg_q  = DATA_W'(sum_q / 19'(fill_q));
    end
    return '{average: avg_q, rejected: reject};
  endfunction

  // driver: offers pending samples, predicts each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      raw_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_averages.push_back(filter_sample(raw_sample_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (!sender_hold && pending_samples.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          raw_sample_i <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result beats, drives the receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    srma_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_averages.size() == 0) begin
          $error("result with nothing expected: average %0d rejected %0d",
                 average_o, rejected_o);
          error_count++;
        end else begin
          want = expected_averages.pop_front();
          if (average_o !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, average_o);
            error_count++;
          end
          if (rejected_o !== want.rejected) begin
            $error("rejected: expected %0d, actual %0d", want.rejected, rejected_o);
            error_count++;
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("FAIL spike_rejecting_moving_average_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || expected_averages.size() != 0 || in_valid_i);
  endtask

  task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SPIKE_THRESHOLD) thr_q = value;
    else max_q = value;
  endtask

  task automatic set_config(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] maxv);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_register(REG_SPIKE_THRESHOLD, thr);
    write_register(REG_SAMPLE_LIMIT, maxv);
    @(negedge clk_i);
  endtask

  // mostly samples around a center, some aliased by multiples of the modulus
  function automatic logic [DATA_W-1:0] pick_sample(input int center);
    int modulus;
    int span;
    int s;
    int kmax;
    modulus = int'(max_q) + 1;
    if ($urandom_range(99) < 30) return DATA_W'($urandom);
    span = int'(thr_q) + int'(thr_q) / 4 + 4;
    s    = center + int'($urandom_range(0, 2 * span)) - span;
    if (s < 0) s = 0;
    if (s > int'(max_q)) s = int'(max_q);
    kmax = (65535 - s) / modulus;
    if ($urandom_range(1)) s += modulus * int'($urandom_range(0, kmax));
    return DATA_W'(s);
  endfunction

  initial begin : stimulus
    int          center;
    logic [15:0] thr;
    logic [15:0] maxv;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset registers, window fill, then low and high spikes
    foreach (ring_q[i]) ;
    pending_samples = '{16'd0, 16'hFFFF, 16'd4096, 16'd4095,
                        16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
                        16'd1300, 16'd3000, 16'd1648};
    // widest threshold and modulus: upper limit must not wrap
    set_config(16'hFFFF, 16'hFFFF);
    pending_samples = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd40000};
    // modulus of one, zero threshold: every sample reduces to zero
    set_config(16'd0, 16'd0);
    pending_samples = '{16'hFFFF, 16'h8000};
    // threshold above the average: no low limit at all
    set_config(16'hFFFF, 16'd0);
    pending_samples = '{16'h5A5A, 16'hA5A5, 16'h0001, 16'hFFFE, 16'd7, 16'd9};

    for (int round = 0; round < NUM_ROUNDS; round++) begin
      case (round)
        0: begin thr = THRESHOLD_RST; maxv = MAX_VALUE_RST; end
        1: begin thr = 16'd0;         maxv = 16'hFFFF;      end
        2: begin thr = 16'hFFFF;      maxv = 16'd1;         end
        3: begin thr = 16'd1;         maxv = 16'hFFFF;      end
        default: begin
          maxv = $urandom_range(1) ? 16'($urandom_range(1, 65535))
                                   : 16'($urandom_range(1, 255));
          thr  = ($urandom_range(3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, maxv / 4));
        end
      endcase
      set_config(thr, maxv);
      case (round % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (round == 4) hold_requests++;
      center = $urandom_range(0, max_q);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(99) < 5) center = $urandom_range(0, max_q);
        pending_samples.push_back(pick_sample(center));
      end
      if (round == 9) begin
        while (pending_samples.size() > ROUND_ITEMS / 2) @(negedge clk_i);
        sender_hold = 1'b1;
        do @(negedge clk_i);
        while (expected_averages.size() != 0 || in_valid_i);
        sender_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS spike_rejecting_moving_average_unit");
    end else begin
      $display("FAIL spike_rejecting_moving_average_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
